FILE: src/lkvc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared codes and control types for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	// Command codes on the request channel
	localparam logic [1:0] CMD_GET    = 2'd0;
	localparam logic [1:0] CMD_PUT    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	// What the slot unit does with the slot under scan
	typedef enum logic [1:0] {
		MODE_FIND   = 2'd0,
		MODE_RECENT = 2'd1,
		MODE_DROP   = 2'd2,
		MODE_PUT    = 2'd3
	} mode_t;

	// Control from the sequencer to the slot unit
	typedef struct packed {
		mode_t mode;
		logic  hit;
	} slot_ctl_t;

	// Per-slot decision from the slot unit
	typedef struct packed {
		logic match;
		logic slot_free;
		logic rank_we;
	} slot_flags_t;

endpackage
`default_nettype wire

FILE: src/lkvc_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_store
// Key, value and recency rank memories: one read port with registered data,
// one write port. Keys and values are written together, ranks on their own.
// ----------------------------------------------------------------------------
module lkvc_store #(
	parameter int ENTRIES    = 16,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                        clk,
	input  wire logic [$clog2(ENTRIES)-1:0]  raddr,
	output logic      [31:0]                 rd_key,
	output logic      [VALUE_BITS-1:0]       rd_value,
	output logic      [$clog2(ENTRIES)-1:0]  rd_rank,
	input  wire logic [$clog2(ENTRIES)-1:0]  waddr,
	input  wire logic                        entry_we,
	input  wire logic [31:0]                 wr_key,
	input  wire logic [VALUE_BITS-1:0]       wr_value,
	input  wire logic                        rank_we,
	input  wire logic [$clog2(ENTRIES)-1:0]  wr_rank
);

	localparam int IDX_W = $clog2(ENTRIES);

	logic [31:0]           key_mem   [ENTRIES];
	logic [VALUE_BITS-1:0] value_mem [ENTRIES];
	logic [IDX_W-1:0]      rank_mem  [ENTRIES];

	// Read all three arrays at the scan address
	always_ff @(posedge clk) begin
		rd_key   <= key_mem[raddr];
		rd_value <= value_mem[raddr];
		rd_rank  <= rank_mem[raddr];
	end

	// Write back the slot that the scan just processed
	always_ff @(posedge clk) begin
		if (entry_we) begin
			key_mem[waddr]   <= wr_key;
			value_mem[waddr] <= wr_value;
		end
		if (rank_we) begin
			rank_mem[waddr] <= wr_rank;
		end
	end

endmodule
`default_nettype wire

FILE: src/lkvc_slot_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_slot_alu
// Shared per-slot unit: key compare during lookup, rank increment, decrement
// and eviction test during the update scan.
// ----------------------------------------------------------------------------
module lkvc_slot_alu #(
	parameter int ENTRIES = 16
) (
	input  wire lkvc_pkg::slot_ctl_t            ctl,
	input  wire logic [$clog2(ENTRIES)-1:0]     idx,
	input  wire logic [$clog2(ENTRIES)-1:0]     hit_slot,
	input  wire logic [$clog2(ENTRIES)-1:0]     hit_rank,
	input  wire logic [$clog2(ENTRIES+1)-1:0]   cap_m1,
	input  wire logic                           slot_valid,
	input  wire logic [$clog2(ENTRIES)-1:0]     slot_rank,
	input  wire logic [31:0]                    slot_key,
	input  wire logic [31:0]                    key,
	output lkvc_pkg::slot_flags_t               flags,
	output logic      [$clog2(ENTRIES)-1:0]     new_rank
);
	import lkvc_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	logic             at_hit;
	logic [IDX_W-1:0] rank_adj;
	logic             evict;

	assign at_hit = ctl.hit && (idx == hit_slot);

	// Rank after the matching entry is dropped, then the eviction test
	assign rank_adj = (ctl.hit && (slot_rank > hit_rank)) ? slot_rank - 1'b1 : slot_rank;
	assign evict    = CNT_W'(rank_adj) >= cap_m1;

	always_comb begin
		flags.match     = slot_valid && (slot_key == key);
		flags.slot_free = !slot_valid;
		flags.rank_we   = 1'b0;
		new_rank        = slot_rank;
		case (ctl.mode)
			MODE_FIND: begin
				flags.rank_we = 1'b0;
			end
			MODE_RECENT: begin
				// move the hit to the front, age the newer ones
				flags.rank_we = slot_valid;
				if (at_hit) begin
					new_rank = '0;
				end else if (slot_rank < hit_rank) begin
					new_rank = slot_rank + 1'b1;
				end
			end
			MODE_DROP: begin
				// free the hit, close the gap behind it
				flags.slot_free = !slot_valid || at_hit;
				flags.rank_we   = slot_valid && !at_hit && (slot_rank > hit_rank);
				new_rank        = slot_rank - 1'b1;
			end
			MODE_PUT: begin
				// drop the old copy, evict the oldest, age the survivors
				flags.slot_free = !slot_valid || at_hit || evict;
				flags.rank_we   = !flags.slot_free;
				new_rank        = rank_adj + 1'b1;
			end
			default: begin
				flags.rank_we = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: src/lru_key_value_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A request beat carries a command (get, put, remove, clear), a 32-bit key and
// a value handle; each request returns one response beat with hit, value and
// entry count. The block scans its key, value and rank memories through one
// read port, one slot per cycle: a lookup scan covers every slot, and an
// update scan over every slot follows a get hit, any put or a remove hit;
// a get or remove miss skips the update scan and a clear runs no scan at
// all. A new request is taken while a response still waits. Reset leaves
// the store empty; no clearing pass is needed, valid bits are flip-flops.
// capacity_limit resets to 16; zero acts as one, values above ENTRIES act
// as ENTRIES.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
	parameter int ENTRIES    = 16,
	parameter int VALUE_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               cfg_wr_en,
	input  wire logic [4:0]         cfg_wr_data,
	// request channel
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire logic [1:0]         cmd,
	input  wire logic signed [31:0] lookup_key,
	input  wire logic [31:0]        write_value,
	// response channel
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output logic                    hit,
	output logic [31:0]             read_value,
	output logic [4:0]              entry_count
);
	import lkvc_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CAP_W = (CNT_W > 5) ? CNT_W : 5;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_FIND   = 4'b0010,
		ST_UPDATE = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	state_t                state_q;
	logic [4:0]            cap_limit_q;
	logic [ENTRIES-1:0]    valid_q;
	logic [CNT_W-1:0]      count_q;

	logic [1:0]            cmd_q;
	logic [31:0]           key_q;
	logic [VALUE_BITS-1:0] wval_q;
	logic                  hit_q;
	logic [IDX_W-1:0]      hit_slot_q;
	logic [IDX_W-1:0]      hit_rank_q;
	logic [VALUE_BITS-1:0] hit_value_q;
	logic                  ins_done_q;

	logic                  issuing_q;
	logic [IDX_W-1:0]      addr_q;
	logic                  vld_s1;
	logic [IDX_W-1:0]      idx_s1;

	logic                  rsp_valid_q;
	logic                  rsp_hit_q;
	logic [31:0]           rsp_value_q;
	logic [4:0]            rsp_count_q;

	logic [31:0]           rd_key;
	logic [VALUE_BITS-1:0] rd_value;
	logic [IDX_W-1:0]      rd_rank;

	logic [CAP_W-1:0]      cap_ext;
	logic [CNT_W-1:0]      cap_eff;
	logic [CNT_W-1:0]      cap_m1;
	slot_ctl_t             ctl;
	slot_flags_t           flags;
	logic [IDX_W-1:0]      new_rank;
	logic                  slot_valid;
	logic                  insert;
	logic                  pass_end;
	logic                  hit_now;
	logic [CNT_W-1:0]      cnt_left;
	logic [CNT_W-1:0]      put_count;
	logic [CNT_W-1:0]      next_count;
	logic                  rsp_free;

	// Clamp the capacity register to 1..ENTRIES
	always_comb begin
		cap_ext = CAP_W'(cap_limit_q);
		if (cap_ext == '0) begin
			cap_eff = CNT_W'(1);
		end else if (cap_ext > CAP_W'(ENTRIES)) begin
			cap_eff = CNT_W'(ENTRIES);
		end else begin
			cap_eff = CNT_W'(cap_ext);
		end
	end
	assign cap_m1 = cap_eff - 1'b1;

	// Select the slot unit operation for the current scan
	always_comb begin
		ctl.hit = hit_q;
		if (state_q == ST_FIND) begin
			ctl.mode = MODE_FIND;
		end else begin
			case (cmd_q)
				CMD_GET:    ctl.mode = MODE_RECENT;
				CMD_PUT:    ctl.mode = MODE_PUT;
				CMD_REMOVE: ctl.mode = MODE_DROP;
				default:    ctl.mode = MODE_FIND;
			endcase
		end
	end

	assign slot_valid = valid_q[idx_s1];

	lkvc_slot_alu #(
		.ENTRIES (ENTRIES)
	) u_alu (
		.ctl        (ctl),
		.idx        (idx_s1),
		.hit_slot   (hit_slot_q),
		.hit_rank   (hit_rank_q),
		.cap_m1     (cap_m1),
		.slot_valid (slot_valid),
		.slot_rank  (rd_rank),
		.slot_key   (rd_key),
		.key        (key_q),
		.flags      (flags),
		.new_rank   (new_rank)
	);

	// First free slot of a put scan takes the new pair
	assign insert = (state_q == ST_UPDATE) && vld_s1 && (cmd_q == CMD_PUT) &&
		flags.slot_free && !ins_done_q;

	lkvc_store #(
		.ENTRIES    (ENTRIES),
		.VALUE_BITS (VALUE_BITS)
	) u_store (
		.clk      (clk),
		.raddr    (addr_q),
		.rd_key   (rd_key),
		.rd_value (rd_value),
		.rd_rank  (rd_rank),
		.waddr    (idx_s1),
		.entry_we (insert),
		.wr_key   (key_q),
		.wr_value (wval_q),
		.rank_we  ((state_q == ST_UPDATE) && vld_s1 && (flags.rank_we || insert)),
		.wr_rank  (insert ? '0 : new_rank)
	);

	assign pass_end = vld_s1 && (idx_s1 == LAST_IDX);
	assign hit_now  = hit_q || (vld_s1 && flags.match);

	// Count after the item commits
	assign cnt_left  = count_q - CNT_W'(hit_q);
	assign put_count = ((cnt_left >= cap_eff) ? cap_m1 : cnt_left) + 1'b1;
	always_comb begin
		case (cmd_q)
			CMD_GET:    next_count = count_q;
			CMD_PUT:    next_count = put_count;
			CMD_REMOVE: next_count = hit_q ? count_q - 1'b1 : count_q;
			default:    next_count = '0;
		endcase
	end

	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);

	// Capture the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_limit_q <= 5'd16;
		end else if (cfg_wr_en) begin
			cap_limit_q <= cfg_wr_data;
		end
	end

	// Advance the slot scan address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			addr_q    <= '0;
			vld_s1    <= 1'b0;
		end else begin
			vld_s1 <= issuing_q;
			if (issuing_q) begin
				if (addr_q == LAST_IDX) begin
					issuing_q <= 1'b0;
					addr_q    <= '0;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end
			if (req_valid && req_ready && (cmd != CMD_CLEAR)) begin
				issuing_q <= 1'b1;
				addr_q    <= '0;
			end else if ((state_q == ST_FIND) && pass_end &&
				((cmd_q == CMD_PUT) || hit_now)) begin
				issuing_q <= 1'b1;
				addr_q    <= '0;
			end
		end
	end

	// Hold the pipeline index of the slot in flight
	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
	end

	// Latch the request beat and the lookup result
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_q  <= cmd;
			key_q  <= lookup_key;
			wval_q <= VALUE_BITS'(write_value);
		end
		if ((state_q == ST_FIND) && vld_s1 && flags.match) begin
			hit_slot_q  <= idx_s1;
			hit_rank_q  <= rd_rank;
			hit_value_q <= rd_value;
		end
	end

	// Sequence the scans and commit state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			count_q    <= '0;
			hit_q      <= 1'b0;
			ins_done_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						hit_q   <= 1'b0;
						state_q <= (cmd == CMD_CLEAR) ? ST_RESULT : ST_FIND;
					end
				end
				ST_FIND: begin
					if (vld_s1 && flags.match) begin
						hit_q <= 1'b1;
					end
					if (pass_end) begin
						ins_done_q <= 1'b0;
						if ((cmd_q == CMD_PUT) || hit_now) begin
							state_q <= ST_UPDATE;
						end else begin
							state_q <= ST_RESULT;
						end
					end
				end
				ST_UPDATE: begin
					if (vld_s1) begin
						if (insert) begin
							valid_q[idx_s1] <= 1'b1;
							ins_done_q      <= 1'b1;
						end else if (cmd_q != CMD_GET) begin
							valid_q[idx_s1] <= !flags.slot_free;
						end
					end
					if (pass_end) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (rsp_free) begin
						count_q <= next_count;
						if (cmd_q == CMD_CLEAR) begin
							valid_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the response beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_RESULT) && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RESULT) && rsp_free) begin
			rsp_hit_q   <= (cmd_q != CMD_CLEAR) && hit_q;
			rsp_value_q <= ((cmd_q == CMD_GET) && hit_q) ? 32'(hit_value_q) : '0;
			rsp_count_q <= 5'(next_count);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign hit         = rsp_hit_q;
	assign read_value  = rsp_value_q;
	assign entry_count = rsp_count_q;

endmodule
`default_nettype wire

FILE: bench/lru_key_value_cache_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb
// Self-checking bench for the LRU key-value cache.
// ----------------------------------------------------------------------------
// Every accepted request beat is run through an LRU store kept inside the
// bench, and the response it should produce is queued. Each response beat is
// compared field by field against the oldest queued response. Directed tests
// cover the empty store, key and value extremes, replacement, removal, clear
// and the capacity corner cases; random phases then mix all four commands
// over small key pools at several capacity settings, with random gaps on the
// request side and random back-pressure on the response side.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lkvc_pkg::*;

	localparam int SLOTS       = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 40;

	typedef struct packed {
		logic        hit;
		logic [31:0] value;
		logic [4:0]  count;
	} cache_rsp_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [4:0]  cfg_wr_data;
	logic        req_valid;
	logic        req_ready;
	logic [1:0]  cmd;
	logic [31:0] lookup_key;
	logic [31:0] write_value;
	logic        rsp_valid;
	logic        rsp_ready;
	logic        hit;
	logic [31:0] read_value;
	logic [4:0]  entry_count;

	// Store mirror: slot contents, recency age (0 = most recent) and live count
	logic        slot_used [SLOTS];
	logic [31:0] slot_key  [SLOTS];
	logic [31:0] slot_val  [SLOTS];
	int unsigned slot_age  [SLOTS];
	int unsigned live_entries;
	logic [4:0]  capacity_q;

	cache_rsp_t  pending_rsp[$];
	int          fail_count;
	int          cycle_count;
	bit          tx_steady;
	bit          rx_steady;

	lru_key_value_cache u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.cmd         (cmd),
		.lookup_key  (lookup_key),
		.write_value (write_value),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.hit         (hit),
		.read_value  (read_value),
		.entry_count (entry_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(40, 120);
	endfunction

	function automatic int find_slot(input logic [31:0] key);
		for (int i = 0; i < SLOTS; i++)
			if (slot_used[i] && slot_key[i] == key)
				return i;
		return -1;
	endfunction

	function automatic void make_newest(input int s);
		int unsigned r;
		r = slot_age[s];
		for (int i = 0; i < SLOTS; i++)
			if (slot_used[i] && slot_age[i] < r)
				slot_age[i]++;
		slot_age[s] = 0;
	endfunction

	function automatic void free_slot(input int s);
		int unsigned r;
		r = slot_age[s];
		slot_used[s] = 1'b0;
		for (int i = 0; i < SLOTS; i++)
			if (slot_used[i] && slot_age[i] > r)
				slot_age[i]--;
		if (live_entries > 0)
			live_entries--;
	endfunction

	function automatic void evict_lru();
		int oldest;
		oldest = -1;
		for (int i = 0; i < SLOTS; i++)
			if (slot_used[i] && (oldest < 0 || slot_age[i] > slot_age[oldest]))
				oldest = i;
		if (oldest >= 0)
			free_slot(oldest);
		else
			live_entries = 0;
	endfunction

	// Apply one request to the mirror and return the response it produces
	function automatic cache_rsp_t lru_apply(input logic [1:0] op, input logic [31:0] key,
			input logic [31:0] value);
		cache_rsp_t  rsp;
		int          s;
		int          free;
		int unsigned cap;
		rsp = '0;
		case (op)
			CMD_GET: begin
				s = find_slot(key);
				if (s >= 0) begin
					rsp.hit   = 1'b1;
					rsp.value = slot_val[s];
					make_newest(s);
				end
			end
			CMD_PUT: begin
				cap = (capacity_q == 0) ? 1 : (capacity_q > SLOTS) ? SLOTS : capacity_q;
				s = find_slot(key);
				if (s >= 0) begin
					rsp.hit = 1'b1;
					free_slot(s);
				end
				while (live_entries >= cap)
					evict_lru();
				free = -1;
				for (int i = 0; i < SLOTS; i++)
					if (!slot_used[i] && free < 0)
						free = i;
				if (free >= 0) begin
					for (int i = 0; i < SLOTS; i++)
						if (slot_used[i])
							slot_age[i]++;
					slot_used[free] = 1'b1;
					slot_key[free]  = key;
					slot_val[free]  = value;
					slot_age[free]  = 0;
					live_entries++;
				end
			end
			CMD_REMOVE: begin
				s = find_slot(key);
				if (s >= 0) begin
					rsp.hit = 1'b1;
					free_slot(s);
				end
			end
			default: begin
				for (int i = 0; i < SLOTS; i++)
					slot_used[i] = 1'b0;
				live_entries = 0;
			end
		endcase
		rsp.count = live_entries[4:0];
		return rsp;
	endfunction

	// Drive one request beat; predict its response when it is accepted.
	// Leave valid high when the next beat follows at once.
	task automatic send_request(input logic [1:0] op, input logic [31:0] key,
			input logic [31:0] value);
		int gap;
		cmd         = op;
		lookup_key  = key;
		write_value = value;
		req_valid   = 1'b1;
		do @(posedge clk); while (!req_ready);
		pending_rsp = {pending_rsp, lru_apply(op, key, value)};
		@(negedge clk);
		gap = tx_steady ? 0 : idle_len();
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Write capacity_limit once the block has drained
	task automatic set_capacity(input logic [4:0] limit);
		req_valid = 1'b0;
		wait (pending_rsp.size() == 0);
		repeat (4) @(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = limit;
		@(posedge clk);
		capacity_q = limit;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Response back-pressure: random stalls unless held steady
	initial begin
		int rx_hold;
		rsp_ready = 1'b0;
		rx_hold   = 0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
			end else if (rx_steady || $urandom_range(0, 3) != 0) begin
				rsp_ready = 1'b1;
				rx_hold   = $urandom_range(0, 6);
			end else begin
				rsp_ready = 1'b0;
				rx_hold   = idle_len();
			end
		end
	end

	// Compare each response beat with the oldest prediction
	always @(posedge clk) begin
		cache_rsp_t want;
		if (rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response hit %0b value %h count %0d", $time,
					hit, read_value, entry_count);
				fail_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (hit !== want.hit) begin
					$display("%0t: hit mismatch expected %0b actual %0b", $time,
						want.hit, hit);
					fail_count++;
				end
				if (read_value !== want.value) begin
					$display("%0t: read_value mismatch expected %h actual %h", $time,
						want.value, read_value);
					fail_count++;
				end
				if (entry_count !== want.count) begin
					$display("%0t: entry_count mismatch expected %0d actual %0d", $time,
						want.count, entry_count);
					fail_count++;
				end
			end
		end
	end

	// Miss paths and clear on an empty store
	task automatic test_empty_store();
		send_request(CMD_GET, 32'h0000_0000, 32'h0);
		send_request(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
		send_request(CMD_CLEAR, 32'h0000_0000, 32'hFFFF_FFFF);
	endtask

	// Key and value extremes, replacement of a live key, remove and clear
	task automatic test_field_extremes();
		send_request(CMD_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
		send_request(CMD_PUT, 32'h7FFF_FFFF, 32'h0000_0000);
		send_request(CMD_PUT, 32'hFFFF_FFFF, 32'h5555_AAAA);
		send_request(CMD_PUT, 32'h0000_0000, 32'hAAAA_5555);
		send_request(CMD_GET, 32'h8000_0000, 32'h0);
		send_request(CMD_GET, 32'h7FFF_FFFF, 32'h0);
		send_request(CMD_GET, 32'hFFFF_FFFF, 32'h0);
		send_request(CMD_GET, 32'h0000_0000, 32'h0);
		send_request(CMD_PUT, 32'h8000_0000, 32'h1234_5678);
		send_request(CMD_GET, 32'h8000_0000, 32'h0);
		send_request(CMD_REMOVE, 32'h7FFF_FFFF, 32'h0);
		send_request(CMD_REMOVE, 32'h7FFF_FFFF, 32'h0);
		send_request(CMD_CLEAR, 32'h0, 32'h0);
	endtask

	// Eviction order, capacity zero acting as one, capacity above the slot count
	task automatic test_capacity_edges();
		set_capacity(5'd3);
		send_request(CMD_PUT, 32'h0000_00A1, 32'h0000_0001);
		send_request(CMD_PUT, 32'h0000_00B2, 32'h0000_0002);
		send_request(CMD_PUT, 32'h0000_00C3, 32'h0000_0003);
		send_request(CMD_GET, 32'h0000_00A1, 32'h0);
		send_request(CMD_PUT, 32'h0000_00D4, 32'h0000_0004);
		send_request(CMD_GET, 32'h0000_00B2, 32'h0);
		set_capacity(5'd0);
		send_request(CMD_PUT, 32'h0000_00E5, 32'h0000_0005);
		set_capacity(5'd31);
		send_request(CMD_PUT, 32'h0000_00F6, 32'h0000_0006);
	endtask

	// Random command mix over a small key pool so that hits and evictions are common
	task automatic test_random_mix(input logic [4:0] limit, input int pool_n, input int n_items);
		logic [31:0] key_pool[$];
		logic [31:0] key;
		logic [1:0]  op;
		int          r;
		set_capacity(limit);
		key_pool.delete();
		for (int i = 0; i < pool_n; i++)
			key_pool = {key_pool, 32'($urandom())};
		for (int n = 0; n < n_items; n++) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				op = CMD_GET;
			else if (r < 78)
				op = CMD_PUT;
			else if (r < 95)
				op = CMD_REMOVE;
			else
				op = CMD_CLEAR;
			if ($urandom_range(0, 99) < 85)
				key = key_pool[$urandom_range(0, pool_n - 1)];
			else
				key = $urandom();
			send_request(op, key, $urandom());
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		req_valid   = 1'b0;
		cmd         = CMD_GET;
		lookup_key  = '0;
		write_value = '0;
		fail_count  = 0;
		cycle_count = 0;
		tx_steady   = 1'b0;
		rx_steady   = 1'b0;
		capacity_q  = 5'd16;
		live_entries = 0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_used[i] = 1'b0;
			slot_key[i]  = '0;
			slot_val[i]  = '0;
			slot_age[i]  = 0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_store();
		test_field_extremes();
		test_capacity_edges();

		test_random_mix(5'd16, 24, 140);
		test_random_mix(5'd31, 20, 110);
		test_random_mix(5'd0, 4, 90);
		test_random_mix(5'd1, 3, 80);
		test_random_mix(5'd5, 9, 110);
		test_random_mix(5'd17, 30, 120);
		test_random_mix(5'($urandom_range(2, 15)), 14, 110);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		test_random_mix(5'd12, 16, 110);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		test_random_mix(5'd16, 20, 60);

		// Drain, then let the block settle
		req_valid = 1'b0;
		wait (pending_rsp.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
